>>> sv/spdpc_pkg.sv
package spdpc_pkg;

  localparam int ROTOR_TEETH    = 100;
  localparam int COUNTS_PER_REV = 40000;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int AW = 45;
  localparam int PW = 64;
  localparam int BW = 32;
  localparam int SH_W = 5;
  localparam int CNT_W = $clog2(PW);
  localparam int TICK_W = 20;
  localparam int TBL_W = 7;
  localparam int TABLE_N = 1 << TBL_W;
  localparam int SIN_W = 18;
  localparam int CUR_W = 18;
  localparam int MW = $clog2(COUNTS_PER_REV + 1);

  localparam int DEN_THETA = COUNTS_PER_REV * 256;
  localparam int DW_T = $clog2(DEN_THETA + 1);
  localparam int DW = (DW_T > 20) ? DW_T : 20;

  localparam logic [BW-1:0] TWO_PI_Q24 = 32'd105414357;
  localparam logic signed [AW-1:0] TRAJ_C5 = 45'sd6325;
  localparam logic signed [AW-1:0] TRAJ_C4 = 45'sd158122;
  localparam logic signed [AW-1:0] TRAJ_C3 = 45'sd1054146;
  localparam logic [BW-1:0] ADC_TO_AMP_Q24 = 32'd13278;
  localparam logic [BW-1:0] INV_KM_Q24 = 32'd111848107;
  localparam logic [BW-1:0] KM_Q24 = 32'd2516582;
  localparam logic [31:0] VOLT_LIMIT = 32'd786432;
  localparam logic [DW-1:0] PWM_DIV = DW'(819200);
  localparam logic [DW-1:0] TICKS_PER_S = DW'(1000);
  localparam logic signed [AW-1:0] POLY_LIMIT = 45'sd4398046511104;

  localparam logic [CFG_IDX_W-1:0] REG_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RUN = 3'd5;

  typedef logic [4:0] op_t;
  localparam op_t OP_THETA  = 5'd0;
  localparam op_t OP_P1     = 5'd1;
  localparam op_t OP_P2     = 5'd2;
  localparam op_t OP_P3     = 5'd3;
  localparam op_t OP_P4     = 5'd4;
  localparam op_t OP_P5     = 5'd5;
  localparam op_t OP_THETAD = 5'd6;
  localparam op_t OP_DTH    = 5'd7;
  localparam op_t OP_DTHD   = 5'd8;
  localparam op_t OP_T1     = 5'd9;
  localparam op_t OP_T2     = 5'd10;
  localparam op_t OP_MODA   = 5'd11;
  localparam op_t OP_PH     = 5'd12;
  localparam op_t OP_UA     = 5'd13;
  localparam op_t OP_IAD    = 5'd14;
  localparam op_t OP_UB     = 5'd15;
  localparam op_t OP_IBD    = 5'd16;
  localparam op_t OP_IA     = 5'd17;
  localparam op_t OP_IB     = 5'd18;
  localparam op_t OP_BEMF   = 5'd19;
  localparam op_t OP_VA1    = 5'd20;
  localparam op_t OP_BS     = 5'd21;
  localparam op_t OP_VB1    = 5'd22;
  localparam op_t OP_BC     = 5'd23;
  localparam op_t OP_XA     = 5'd24;
  localparam op_t OP_XB     = 5'd25;

  typedef logic [1:0] rnd_t;
  localparam rnd_t RND_NONE = 2'd0;
  localparam rnd_t RND_HALF = 2'd1;
  localparam rnd_t RND_CEIL = 2'd2;

  typedef logic [1:0] sat_t;
  localparam sat_t SAT_NONE = 2'd0;
  localparam sat_t SAT_32   = 2'd1;
  localparam sat_t SAT_42   = 2'd2;

  typedef struct packed {
    logic signed [AW-1:0] a;
    logic [BW-1:0]        b;
    logic                 b_neg;
    logic                 neg;
    logic                 use_div;
    logic [SH_W-1:0]      sh;
    logic [DW-1:0]        den;
    rnd_t                 rnd;
    sat_t                 sat;
  } op_desc_t;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    if (v > PW'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -PW'(64'sd2147483648)) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic logic signed [AW-1:0] clamp42(input logic signed [PW-1:0] v);
    if (v > PW'(POLY_LIMIT)) return POLY_LIMIT;
    if (v < -PW'(POLY_LIMIT)) return -POLY_LIMIT;
    return AW'(v);
  endfunction

  function automatic logic [16:0] quarter_sine(input logic [5:0] i);
    logic [16:0] v;
    case (i)
      6'd0: v = 17'd0;       6'd1: v = 17'd3216;    6'd2: v = 17'd6424;
      6'd3: v = 17'd9616;    6'd4: v = 17'd12785;   6'd5: v = 17'd15924;
      6'd6: v = 17'd19024;   6'd7: v = 17'd22078;   6'd8: v = 17'd25080;
      6'd9: v = 17'd28020;   6'd10: v = 17'd30893;  6'd11: v = 17'd33692;
      6'd12: v = 17'd36410;  6'd13: v = 17'd39040;  6'd14: v = 17'd41576;
      6'd15: v = 17'd44011;  6'd16: v = 17'd46341;  6'd17: v = 17'd48559;
      6'd18: v = 17'd50660;  6'd19: v = 17'd52639;  6'd20: v = 17'd54491;
      6'd21: v = 17'd56212;  6'd22: v = 17'd57798;  6'd23: v = 17'd59244;
      6'd24: v = 17'd60547;  6'd25: v = 17'd61705;  6'd26: v = 17'd62714;
      6'd27: v = 17'd63572;  6'd28: v = 17'd64277;  6'd29: v = 17'd64827;
      6'd30: v = 17'd65220;  6'd31: v = 17'd65457;  6'd32: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [SIN_W-1:0] table_sine(input logic [TBL_W-1:0] p);
    logic [5:0]  r;
    logic [16:0] v;
    r = {1'b0, p[4:0]};
    v = p[5] ? quarter_sine(6'd32 - r) : quarter_sine(r);
    return p[6] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

>>> sv/stepper_pd_position_controller_top.sv
// Channel | Direction | Content
// in_     | request   | tdata: position_count, current_a_raw, current_b_raw
// out_    | result    | tdata: compare_a, direction_a, compare_b, direction_b; tuser: stopped
// cfg_    | write     | cfg_index selects the register, cfg_wdata holds the value
//
// One request runs up to 26 steps through one shared bit-serial multiplier (one
// multiplier bit per cycle) and one restoring divider (one quotient bit per cycle,
// used by ten steps). Once stopped, a request goes straight from idle to done.
// Reset is synchronous, active low, and restores config and control registers only.
// A new request is taken while a finished result waits in the output register;
// the block then holds the next result until out_tready frees it.
module stepper_pd_position_controller_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // position_count[31:0], current_a_raw[43:32], current_b_raw[55:44]
  input  logic [spdpc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // compare_a[15:0], direction_a[16], compare_b[32:17], direction_b[33], zero pad
  output logic [spdpc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // stopped[0]
  output logic [0:0]                           out_tuser,
  input  logic                                 cfg_we,
  input  logic [spdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spdpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import spdpc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_POST = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [31:0] kp_r, kd_r, ga_r, gb_r;
  logic [15:0] period_r;
  logic [TICK_W-1:0] run_r, elapsed_r, et_r;
  logic signed [31:0] last_pos_r, last_tgt_r;
  logic halted_r, zero_r;

  logic [2:0] state_r;
  op_t op_r;
  logic signed [32:0] cnt_r;
  logic [11:0] raw_a_r, raw_b_r;
  logic signed [31:0] theta_r, thetad_r, dtheta_r, dthetad_r, tau_r, u_r;
  logic signed [31:0] iad_r, ibd_r, bemf_r, va_r, vb_r;
  logic signed [AW-1:0] poly_r;
  logic signed [41:0] t1_r;
  logic [MW-1:0] m_r;
  logic signed [SIN_W-1:0] s_r, c_r;
  logic [CUR_W-1:0] ia_r, ib_r;
  logic [15:0] cmp_a_r, cmp_b_r;
  logic dir_a_r, dir_b_r;

  logic [PW-1:0] a_r, p_r, n_r;
  logic [BW-1:0] b_r;
  logic [DW-1:0] rem_r, den_r;
  logic [CNT_W-1:0] dcnt_r;
  logic sgn_r, use_div_r;
  logic [SH_W-1:0] sh_r;
  rnd_t rnd_r;
  sat_t sat_r;

  logic out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic out_stop_r;

  op_desc_t dsc;
  logic signed [31:0] e_v, de_v;
  logic signed [AW-1:0] a_cl;
  logic [PW-1:0] a_mag;
  logic [PW-1:0] rnd_v, n_v;
  logic [DW:0] t_v;
  logic ge_v;
  logic signed [PW-1:0] q_s, res_v, va_sum, vb_sum;
  logic [DW-1:0] r_mod;
  logic [31:0] va_mag, vb_mag, s_mag, c_mag;

  assign e_v  = sat32(PW'(33'(theta_r) - 33'(thetad_r)));
  assign de_v = sat32(PW'(33'(dtheta_r) - 33'(dthetad_r)));
  assign va_mag = va_r[31] ? 32'(-33'(va_r)) : 32'(va_r);
  assign vb_mag = vb_r[31] ? 32'(-33'(vb_r)) : 32'(vb_r);
  assign s_mag = 32'($unsigned(s_r[SIN_W-1] ? -s_r : s_r));
  assign c_mag = 32'($unsigned(c_r[SIN_W-1] ? -c_r : c_r));

  always_comb begin
    dsc = '0;
    dsc.rnd = RND_HALF;
    dsc.sat = SAT_32;
    case (op_r)
      OP_THETA: begin
        dsc.a = AW'(cnt_r); dsc.b = TWO_PI_Q24; dsc.use_div = 1'b1;
        dsc.den = DW'(DEN_THETA);
      end
      OP_P1: begin
        dsc.a = TRAJ_C5; dsc.b = BW'(et_r); dsc.use_div = 1'b1;
        dsc.den = TICKS_PER_S; dsc.sat = SAT_42;
      end
      OP_P2, OP_P3, OP_P4, OP_P5: begin
        dsc.a = poly_r; dsc.b = BW'(et_r); dsc.use_div = 1'b1;
        dsc.den = TICKS_PER_S; dsc.sat = SAT_42;
      end
      OP_THETAD: begin
        dsc.a = poly_r; dsc.b = BW'(1); dsc.sh = SH_W'(8);
      end
      OP_DTH: begin
        dsc.a = AW'(33'(theta_r) - 33'(last_pos_r)); dsc.b = BW'(1000);
        dsc.rnd = RND_NONE;
      end
      OP_DTHD: begin
        dsc.a = AW'(33'(thetad_r) - 33'(last_tgt_r)); dsc.b = BW'(1000);
        dsc.rnd = RND_NONE;
      end
      OP_T1: begin
        dsc.a = AW'(e_v); dsc.b = kp_r; dsc.sh = SH_W'(24); dsc.sat = SAT_NONE;
      end
      OP_T2: begin
        dsc.a = AW'(de_v); dsc.b = kd_r; dsc.sh = SH_W'(24); dsc.sat = SAT_NONE;
      end
      OP_MODA: begin
        dsc.a = AW'(cnt_r); dsc.b = BW'(ROTOR_TEETH); dsc.use_div = 1'b1;
        dsc.den = DW'(COUNTS_PER_REV); dsc.rnd = RND_NONE; dsc.sat = SAT_NONE;
      end
      OP_PH: begin
        dsc.a = AW'($signed({1'b0, m_r})); dsc.b = BW'(TABLE_N); dsc.use_div = 1'b1;
        dsc.den = DW'(COUNTS_PER_REV); dsc.rnd = RND_NONE; dsc.sat = SAT_NONE;
      end
      OP_UA: begin
        dsc.a = AW'(tau_r); dsc.b = s_mag; dsc.b_neg = s_r[SIN_W-1]; dsc.sh = SH_W'(16);
      end
      OP_IAD: begin
        dsc.a = AW'(u_r); dsc.b = INV_KM_Q24; dsc.neg = 1'b1; dsc.sh = SH_W'(24);
      end
      OP_UB: begin
        dsc.a = AW'(tau_r); dsc.b = c_mag; dsc.b_neg = c_r[SIN_W-1]; dsc.sh = SH_W'(16);
      end
      OP_IBD: begin
        dsc.a = AW'(u_r); dsc.b = INV_KM_Q24; dsc.sh = SH_W'(24);
      end
      OP_IA: begin
        dsc.a = AW'($signed({1'b0, raw_a_r})); dsc.b = ADC_TO_AMP_Q24;
        dsc.sh = SH_W'(8); dsc.sat = SAT_NONE;
      end
      OP_IB: begin
        dsc.a = AW'($signed({1'b0, raw_b_r})); dsc.b = ADC_TO_AMP_Q24;
        dsc.sh = SH_W'(8); dsc.sat = SAT_NONE;
      end
      OP_BEMF: begin
        dsc.a = AW'(dthetad_r); dsc.b = KM_Q24; dsc.sh = SH_W'(24);
      end
      OP_VA1: begin
        dsc.a = AW'(sat32(PW'($signed({1'b0, ia_r})) - PW'(iad_r)));
        dsc.b = ga_r; dsc.sh = SH_W'(24); dsc.sat = SAT_NONE;
      end
      OP_BS: begin
        dsc.a = AW'(bemf_r); dsc.b = s_mag; dsc.b_neg = s_r[SIN_W-1]; dsc.sh = SH_W'(16);
      end
      OP_VB1: begin
        dsc.a = AW'(sat32(PW'($signed({1'b0, ib_r})) - PW'(ibd_r)));
        dsc.b = gb_r; dsc.sh = SH_W'(24); dsc.sat = SAT_NONE;
      end
      OP_BC: begin
        dsc.a = AW'(bemf_r); dsc.b = c_mag; dsc.b_neg = c_r[SIN_W-1]; dsc.sh = SH_W'(16);
      end
      OP_XA: begin
        dsc.a = AW'($signed({1'b0, (va_mag > VOLT_LIMIT) ? VOLT_LIMIT : va_mag}));
        dsc.b = BW'(period_r); dsc.use_div = 1'b1; dsc.den = PWM_DIV;
        dsc.rnd = RND_CEIL; dsc.sat = SAT_NONE;
      end
      OP_XB: begin
        dsc.a = AW'($signed({1'b0, (vb_mag > VOLT_LIMIT) ? VOLT_LIMIT : vb_mag}));
        dsc.b = BW'(period_r); dsc.use_div = 1'b1; dsc.den = PWM_DIV;
        dsc.rnd = RND_CEIL; dsc.sat = SAT_NONE;
      end
      default: dsc.a = '0;
    endcase
  end

  assign a_cl  = clamp42(PW'(dsc.a));
  assign a_mag = a_cl[AW-1] ? PW'($unsigned(-a_cl)) : PW'($unsigned(a_cl));

  always_comb begin
    case (rnd_r)
      RND_HALF: rnd_v = use_div_r ? PW'(den_r >> 1) : ((PW'(1) << sh_r) >> 1);
      RND_CEIL: rnd_v = PW'(den_r) - PW'(1);
      default:  rnd_v = '0;
    endcase
  end
  assign n_v  = p_r + rnd_v;
  assign t_v  = {rem_r, n_r[PW-1]};
  assign ge_v = (t_v >= {1'b0, den_r});

  assign q_s = sgn_r ? -$signed(n_r) : $signed(n_r);
  always_comb begin
    case (sat_r)
      SAT_32:  res_v = PW'(sat32(q_s));
      SAT_42:  res_v = PW'(clamp42(q_s));
      default: res_v = q_s;
    endcase
  end
  assign r_mod  = (sgn_r && rem_r != '0) ? DW'(COUNTS_PER_REV) - rem_r : rem_r;
  assign va_sum = -PW'(t1_r) + PW'(iad_r) * 5 - res_v;
  assign vb_sum = -PW'(t1_r) + PW'(ibd_r) * 5 + res_v;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= 32'd1174405;
      kd_r <= 32'd168;
      ga_r <= 32'd33554432;
      gb_r <= 32'd33554432;
      period_r <= 16'd5000;
      run_r <= TICK_W'(10000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP:     kp_r <= cfg_wdata;
        REG_KD:     kd_r <= cfg_wdata;
        REG_GA:     ga_r <= cfg_wdata;
        REG_GB:     gb_r <= cfg_wdata;
        REG_PERIOD: period_r <= cfg_wdata[15:0];
        REG_RUN:    run_r <= cfg_wdata[TICK_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r <= OP_THETA;
      elapsed_r <= '0;
      last_pos_r <= '0;
      last_tgt_r <= '0;
      halted_r <= 1'b0;
      zero_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            raw_a_r <= in_tdata[43:32];
            raw_b_r <= in_tdata[55:44];
            cnt_r <= -33'($signed(in_tdata[31:0]));
            if (halted_r) begin
              zero_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              elapsed_r <= elapsed_r + TICK_W'(1);
              et_r <= elapsed_r + TICK_W'(1);
              op_r <= OP_THETA;
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          a_r <= a_mag;
          b_r <= dsc.b;
          p_r <= '0;
          sgn_r <= a_cl[AW-1] ^ dsc.b_neg ^ dsc.neg;
          use_div_r <= dsc.use_div;
          sh_r <= dsc.sh;
          den_r <= dsc.den;
          rnd_r <= dsc.rnd;
          sat_r <= dsc.sat;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (b_r == '0) begin
            state_r <= S_POST;
          end else begin
            if (b_r[0]) p_r <= p_r + a_r;
            a_r <= a_r << 1;
            b_r <= b_r >> 1;
          end
        end
        S_POST: begin
          rem_r <= '0;
          dcnt_r <= '0;
          if (use_div_r) begin
            n_r <= n_v;
            state_r <= S_DIV;
          end else begin
            n_r <= n_v >> sh_r;
            state_r <= S_WB;
          end
        end
        S_DIV: begin
          rem_r <= ge_v ? DW'(t_v - {1'b0, den_r}) : DW'(t_v);
          n_r <= {n_r[PW-2:0], ge_v};
          dcnt_r <= dcnt_r + CNT_W'(1);
          if (dcnt_r == CNT_W'(PW - 1)) state_r <= S_WB;
        end
        S_WB: begin
          op_r <= op_r + op_t'(1);
          state_r <= (op_r >= OP_XB || (op_r == OP_DTHD && et_r >= run_r)) ?
                     S_DONE : S_LOAD;
          case (op_r)
            OP_THETA:  theta_r <= 32'(res_v);
            OP_P1:     poly_r <= AW'(res_v) - TRAJ_C4;
            OP_P2:     poly_r <= AW'(res_v) + TRAJ_C3;
            OP_P3, OP_P4, OP_P5: poly_r <= AW'(res_v);
            OP_THETAD: thetad_r <= 32'(res_v);
            OP_DTH:    dtheta_r <= 32'(res_v);
            OP_DTHD: begin
              dthetad_r <= 32'(res_v);
              if (et_r >= run_r) begin
                halted_r <= 1'b1;
                last_pos_r <= theta_r;
                last_tgt_r <= thetad_r;
                zero_r <= 1'b1;
              end
            end
            OP_T1:     t1_r <= 42'(res_v);
            OP_T2:     tau_r <= sat32(-PW'(t1_r) - res_v);
            OP_MODA:   m_r <= MW'(r_mod);
            OP_PH: begin
              s_r <= table_sine(n_r[TBL_W-1:0]);
              c_r <= table_sine(n_r[TBL_W-1:0] + TBL_W'(TABLE_N / 4));
            end
            OP_UA, OP_UB: u_r <= 32'(res_v);
            OP_IAD:    iad_r <= 32'(res_v);
            OP_IBD:    ibd_r <= 32'(res_v);
            OP_IA:     ia_r <= CUR_W'(res_v);
            OP_IB:     ib_r <= CUR_W'(res_v);
            OP_BEMF:   bemf_r <= 32'(res_v);
            OP_VA1, OP_VB1: t1_r <= 42'(res_v);
            OP_BS:     va_r <= sat32(va_sum);
            OP_BC:     vb_r <= sat32(vb_sum);
            OP_XA: begin
              cmp_a_r <= period_r - n_r[15:0];
              dir_a_r <= ~va_r[31];
            end
            OP_XB: begin
              cmp_b_r <= period_r - n_r[15:0];
              dir_b_r <= ~vb_r[31];
              last_pos_r <= theta_r;
              last_tgt_r <= thetad_r;
              zero_r <= 1'b0;
            end
            default: ;
          endcase
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            if (zero_r) begin
              out_data_r <= {6'd0, 1'b1, period_r, 1'b1, period_r};
              out_stop_r <= 1'b1;
            end else begin
              out_data_r <= {6'd0, dir_b_r, cmp_b_r, dir_a_r, cmp_a_r};
              out_stop_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
